// File: rtl/core/ema_cb_pkg.sv
// ----------------------------------------------------------------------------
// ema_cb_pkg
// Shared types and constants for the EMA error-rate circuit breaker.
// ----------------------------------------------------------------------------
package ema_cb_pkg;

  localparam int LATENCY_MULTIPLE = 2;
  localparam int MIN_ISOLATION_MS = 100;
  localparam int MAX_ISOLATION_MS = 30000;

  localparam int SIZE_W  = 16;
  localparam int PCT_W   = 7;
  localparam int SMTH_W  = 24;
  localparam int MINC_W  = 32;
  localparam int EPS_W   = 16;
  localparam int LAT_W   = 32;
  localparam int TIME_W  = 48;
  localparam int COST_W  = 48;
  localparam int ISO_W   = 15;
  localparam int TALLY_W = 32;
  localparam int CFG_W   = 32;
  localparam int CAP_W   = LAT_W + $clog2(LATENCY_MULTIPLE + 1);

  localparam int PCT_SCALE = 100;

  localparam logic [SIZE_W-1:0] RST_LONG_SIZE   = 16'd3000;
  localparam logic [SIZE_W-1:0] RST_SHORT_SIZE  = 16'd1500;
  localparam logic [PCT_W-1:0]  RST_LONG_PCT    = 7'd5;
  localparam logic [PCT_W-1:0]  RST_SHORT_PCT   = 7'd10;
  localparam logic [SMTH_W-1:0] RST_LONG_SMOOTH = 24'd16755352;
  localparam logic [SMTH_W-1:0] RST_SHORT_SMOOTH = 24'd16733518;
  localparam logic [MINC_W-1:0] RST_MIN_COST    = 32'd500;
  localparam logic [EPS_W-1:0]  RST_EPS         = 16'd1311;

  typedef enum logic [2:0] {
    CFG_LONG_SIZE   = 3'd0,
    CFG_SHORT_SIZE  = 3'd1,
    CFG_LONG_PCT    = 3'd2,
    CFG_SHORT_PCT   = 3'd3,
    CFG_LONG_SMOOTH = 3'd4,
    CFG_SHORT_SMOOTH = 3'd5,
    CFG_MIN_COST    = 3'd6,
    CFG_EPS         = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OUT_SUCCESS = 2'd0,
    OUT_ERROR   = 2'd1,
    OUT_REJECT  = 2'd2,
    OUT_OTHER   = 2'd3
  } outcome_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_DECODE,
    OP_RESET,
    OP_AVG_S,
    OP_LAT_S,
    OP_COST_HI,
    OP_COST_LO,
    OP_AVG_SIZE,
    OP_MUL_PCT,
    OP_MUL_EPS,
    OP_SUM,
    OP_SUM_SCALE,
    OP_COMMIT,
    OP_BREAK
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RESET,
    S_AVG_S,
    S_LAT_S,
    S_COST_HI,
    S_COST_LO,
    S_AVG_SIZE,
    S_MUL_PCT,
    S_MUL_EPS,
    S_SUM,
    S_SUM_SCALE,
    S_COMMIT,
    S_BREAK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic out_load;
    logic win;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic reject;
    logic broken;
    logic pass;
  } stat_t;

endpackage

// File: rtl/core/ema_error_circuit_breaker.sv
// ----------------------------------------------------------------------------
// ema_error_circuit_breaker
// EMA error-rate circuit breaker with long and short windows.
//
//  Channel  Direction  Handshake          Payload
//  in       input      in_valid/in_stall  func, outcome, latency_us, now_ms
//  out      output     out_valid/out_stall healthy, broken, isolation_ms,
//                                         isolation_count
//  cfg      input      cfg_we             cfg_index, cfg_data
//
// A call completion runs decode, each window's steps and output; one failing
// in the long window skips the short one and goes to break and output, a reset
// runs decode, reset and output, a rejected call or call while broken goes
// from decode to output. Each window runs ten steps on one shared multiply
// slot. One item is processed at a time; the next item is accepted while the
// result register still waits. Reset is synchronous and restores defaults.
// ----------------------------------------------------------------------------
module ema_error_circuit_breaker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [1:0]  in_outcome,
  input  logic [31:0] in_latency_us,
  input  logic [47:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_healthy,
  output logic        out_broken,
  output logic [14:0] out_isolation_ms,
  output logic [31:0] out_isolation_count
);
  import ema_cb_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ema_cb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ema_cb_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_func             (in_func),
    .in_outcome          (in_outcome),
    .in_latency_us       (in_latency_us),
    .in_now_ms           (in_now_ms),
    .cmd                 (cmd),
    .stat                (stat),
    .out_healthy         (out_healthy),
    .out_broken          (out_broken),
    .out_isolation_ms    (out_isolation_ms),
    .out_isolation_count (out_isolation_count)
  );

endmodule

// File: rtl/core/ema_cb_ctrl.sv
// ----------------------------------------------------------------------------
// ema_cb_ctrl
// Sequencer: steps the datapath through decode, reset, both windows, break and output.
// ----------------------------------------------------------------------------
module ema_cb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  ema_cb_pkg::stat_t stat,
  output ema_cb_pkg::cmd_t  cmd
);
  import ema_cb_pkg::*;

  state_t state_r, state_nxt;
  logic   win_r, win_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    win_nxt   = win_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
          win_nxt   = 1'b0;
        end
      end
      S_DECODE: begin
        if (stat.func)
          state_nxt = S_RESET;
        else if (stat.reject || stat.broken)
          state_nxt = S_OUT;
        else
          state_nxt = S_AVG_S;
      end
      S_RESET:      state_nxt = S_OUT;
      S_AVG_S:      state_nxt = S_LAT_S;
      S_LAT_S:      state_nxt = S_COST_HI;
      S_COST_HI:    state_nxt = S_COST_LO;
      S_COST_LO:    state_nxt = S_AVG_SIZE;
      S_AVG_SIZE:   state_nxt = S_MUL_PCT;
      S_MUL_PCT:    state_nxt = S_MUL_EPS;
      S_MUL_EPS:    state_nxt = S_SUM;
      S_SUM:        state_nxt = S_SUM_SCALE;
      S_SUM_SCALE:  state_nxt = S_COMMIT;
      S_COMMIT: begin
        if (!stat.pass) begin
          state_nxt = S_BREAK;
        end else if (!win_r) begin
          state_nxt = S_AVG_S;
          win_nxt   = 1'b1;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_BREAK:      state_nxt = S_OUT;
      S_OUT: begin
        if (out_free)
          state_nxt = S_IDLE;
      end
      default:      state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.load     = 1'b0;
    cmd.out_load = 1'b0;
    cmd.win      = win_r;
    cmd.op       = OP_NONE;
    in_stall     = (state_r != S_IDLE);
    case (state_r)
      S_IDLE:      cmd.load = in_valid;
      S_DECODE:    cmd.op = OP_DECODE;
      S_RESET:     cmd.op = OP_RESET;
      S_AVG_S:     cmd.op = OP_AVG_S;
      S_LAT_S:     cmd.op = OP_LAT_S;
      S_COST_HI:   cmd.op = OP_COST_HI;
      S_COST_LO:   cmd.op = OP_COST_LO;
      S_AVG_SIZE:  cmd.op = OP_AVG_SIZE;
      S_MUL_PCT:   cmd.op = OP_MUL_PCT;
      S_MUL_EPS:   cmd.op = OP_MUL_EPS;
      S_SUM:       cmd.op = OP_SUM;
      S_SUM_SCALE: cmd.op = OP_SUM_SCALE;
      S_COMMIT:    cmd.op = OP_COMMIT;
      S_BREAK:     cmd.op = OP_BREAK;
      S_OUT:       cmd.out_load = out_free;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load)
      out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_r       <= win_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DECODE))
    else $error("accepted item not decoded");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result not presented after load");

  a_break_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BREAK) |=> (state_r == S_OUT))
    else $error("break not followed by output");

endmodule

// File: rtl/core/ema_cb_dp.sv
// ----------------------------------------------------------------------------
// ema_cb_dp
// Datapath: config, window state, shared multiply steps, result registers.
// ----------------------------------------------------------------------------
module ema_cb_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              in_func,
  input  logic [1:0]        in_outcome,
  input  logic [31:0]       in_latency_us,
  input  logic [47:0]       in_now_ms,
  input  ema_cb_pkg::cmd_t  cmd,
  output ema_cb_pkg::stat_t stat,
  output logic              out_healthy,
  output logic              out_broken,
  output logic [14:0]       out_isolation_ms,
  output logic [31:0]       out_isolation_count
);
  import ema_cb_pkg::*;

  logic [SIZE_W-1:0] size_r [2];
  logic [PCT_W-1:0]  pct_r [2];
  logic [SMTH_W-1:0] smooth_r [2];
  logic [MINC_W-1:0] min_cost_r;
  logic [EPS_W-1:0]  eps_r;

  logic [SIZE_W-1:0] samples_r [2];
  logic [SIZE_W-1:0] errors_r [2];
  logic [LAT_W-1:0]  avg_r [2];
  logic [COST_W-1:0] cost_r [2];
  logic              broken_r;
  logic [TIME_W-1:0] last_r;
  logic [ISO_W-1:0]  len_r;
  logic [TALLY_W-1:0] tally_r;
  logic              healthy_r;

  logic              func_r;
  outcome_t          outcome_r;
  logic [LAT_W-1:0]  lat_r;
  logic [TIME_W-1:0] now_r;

  logic [55:0] m0_r;
  logic [56:0] m1_r;
  logic [47:0] m2_r;
  logic [47:0] m3_r;
  logic [47:0] m4_r;
  logic [54:0] m5_r;
  logic [71:0] m6_r;
  logic [COST_W-1:0] sum_r;
  logic [22:0] sp_r;
  logic [54:0] m8_r;

  logic [SIZE_W-1:0] size_w;
  logic [PCT_W-1:0]  pct_w;
  logic [SMTH_W-1:0] s_w;
  logic [LAT_W-1:0]  avg_w;
  logic [COST_W-1:0] cost_w;
  logic [24:0]       oms_w;
  logic [16:0]       k_w;
  logic [CAP_W-1:0]  cap_w;
  logic [LAT_W-1:0]  clat_w;
  logic [COST_W:0]   add_w;
  logic [57:0]       ema_sum_w;
  logic [LAT_W-1:0]  ema_w;
  logic [COST_W-1:0] dec_w;
  logic              err_w;
  logic              warm_w;
  logic              pass_e_w;
  logic              pass_w;
  logic [COST_W-1:0] cost_new_w;
  logic [23:0]       prior_scaled_w;
  logic [TIME_W-1:0] elapsed_w;
  logic [ISO_W:0]    dbl_w;

  assign size_w = size_r[cmd.win];
  assign pct_w  = pct_r[cmd.win];
  assign s_w    = smooth_r[cmd.win];
  assign avg_w  = avg_r[cmd.win];
  assign cost_w = cost_r[cmd.win];
  assign oms_w  = 25'h100_0000 - 25'(s_w);
  assign k_w    = 17'h1_0000 + 17'(eps_r);
  assign cap_w  = CAP_W'(avg_w) * CAP_W'(LATENCY_MULTIPLE);
  assign err_w  = (outcome_r != OUT_SUCCESS);

  always_comb begin
    clat_w = lat_r;
    if (avg_w != '0 && cap_w < CAP_W'(lat_r))
      clat_w = LAT_W'(cap_w);
  end

  assign add_w     = (COST_W+1)'(cost_w) + (COST_W+1)'(clat_w);
  assign ema_sum_w = 58'(m0_r) + 58'(m1_r);
  assign ema_w     = (avg_w == '0) ? lat_r : ema_sum_w[55:24];

  always_comb begin
    dec_w = cost_w;
    if (cost_w != '0) begin
      if (cost_w < COST_W'(min_cost_r))
        dec_w = '0;
      else
        dec_w = m2_r + COST_W'(m3_r[47:24]);
    end
  end

  always_comb begin
    cost_new_w = dec_w;
    pass_e_w   = 1'b1;
    if (err_w && clat_w != '0) begin
      cost_new_w = sum_r;
      pass_e_w   = (72'({m8_r, 16'h0}) <= m6_r);
    end
  end

  assign warm_w         = (samples_r[cmd.win] < size_w);
  assign prior_scaled_w = 24'(17'(errors_r[cmd.win]) + 17'd1) * 24'(PCT_SCALE);

  always_comb begin
    pass_w = pass_e_w;
    if (warm_w)
      pass_w = err_w ? (prior_scaled_w <= 24'(sp_r)) : 1'b1;
  end

  assign elapsed_w = now_r - last_r;
  assign dbl_w     = {len_r, 1'b0};

  assign stat.func   = func_r;
  assign stat.reject = (outcome_r == OUT_REJECT);
  assign stat.broken = broken_r;
  assign stat.pass   = pass_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r[0]   <= RST_LONG_SIZE;
      size_r[1]   <= RST_SHORT_SIZE;
      pct_r[0]    <= RST_LONG_PCT;
      pct_r[1]    <= RST_SHORT_PCT;
      smooth_r[0] <= RST_LONG_SMOOTH;
      smooth_r[1] <= RST_SHORT_SMOOTH;
      min_cost_r  <= RST_MIN_COST;
      eps_r       <= RST_EPS;
      for (int w = 0; w < 2; w++) begin
        samples_r[w] <= '0;
        errors_r[w]  <= '0;
        avg_r[w]     <= '0;
        cost_r[w]    <= '0;
      end
      broken_r  <= 1'b0;
      last_r    <= '0;
      len_r     <= ISO_W'(MIN_ISOLATION_MS);
      tally_r   <= '0;
      healthy_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_LONG_SIZE:    size_r[0]   <= cfg_data[SIZE_W-1:0];
          CFG_SHORT_SIZE:   size_r[1]   <= cfg_data[SIZE_W-1:0];
          CFG_LONG_PCT:     pct_r[0]    <= cfg_data[PCT_W-1:0];
          CFG_SHORT_PCT:    pct_r[1]    <= cfg_data[PCT_W-1:0];
          CFG_LONG_SMOOTH:  smooth_r[0] <= cfg_data[SMTH_W-1:0];
          CFG_SHORT_SMOOTH: smooth_r[1] <= cfg_data[SMTH_W-1:0];
          CFG_MIN_COST:     min_cost_r  <= cfg_data[MINC_W-1:0];
          CFG_EPS:          eps_r       <= cfg_data[EPS_W-1:0];
          default:          eps_r       <= eps_r;
        endcase
      end
      case (cmd.op)
        OP_DECODE: healthy_r <= (outcome_r == OUT_REJECT) && !func_r;
        OP_RESET: begin
          for (int w = 0; w < 2; w++) begin
            if (samples_r[w] < size_r[w]) begin
              samples_r[w] <= '0;
              errors_r[w]  <= '0;
              avg_r[w]     <= '0;
            end
            cost_r[w] <= '0;
          end
          last_r   <= now_r;
          broken_r <= 1'b0;
        end
        OP_COMMIT: begin
          if (!err_w)
            avg_r[cmd.win] <= ema_w;
          cost_r[cmd.win] <= cost_new_w;
          if (warm_w) begin
            samples_r[cmd.win] <= samples_r[cmd.win] + 16'd1;
            if (err_w && errors_r[cmd.win] != 16'hFFFF)
              errors_r[cmd.win] <= errors_r[cmd.win] + 16'd1;
          end
          if (pass_w && cmd.win)
            healthy_r <= 1'b1;
        end
        OP_BREAK: begin
          if (!broken_r) begin
            broken_r <= 1'b1;
            tally_r  <= tally_r + 32'd1;
            if (now_r >= last_r && elapsed_w >= TIME_W'(MAX_ISOLATION_MS))
              len_r <= ISO_W'(MIN_ISOLATION_MS);
            else if (dbl_w < (ISO_W+1)'(MAX_ISOLATION_MS))
              len_r <= dbl_w[ISO_W-1:0];
            else
              len_r <= ISO_W'(MAX_ISOLATION_MS);
          end
        end
        default: healthy_r <= healthy_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r    <= in_func;
      outcome_r <= outcome_t'(in_outcome);
      lat_r     <= in_latency_us;
      now_r     <= in_now_ms;
    end
    case (cmd.op)
      OP_AVG_S:     m0_r <= 56'(avg_w) * 56'(s_w);
      OP_LAT_S:     m1_r <= 57'(lat_r) * 57'(oms_w);
      OP_COST_HI:   m2_r <= 48'(cost_w[47:24]) * 48'(s_w);
      OP_COST_LO:   m3_r <= 48'(cost_w[23:0]) * 48'(s_w);
      OP_AVG_SIZE:  m4_r <= 48'(avg_w) * 48'(size_w);
      OP_MUL_PCT:   m5_r <= 55'(m4_r) * 55'(pct_w);
      OP_MUL_EPS:   m6_r <= 72'(m5_r) * 72'(k_w);
      OP_SUM: begin
        sum_r <= add_w[COST_W] ? {COST_W{1'b1}} : add_w[COST_W-1:0];
        sp_r  <= 23'(size_w) * 23'(pct_w);
      end
      OP_SUM_SCALE: m8_r <= 55'(sum_r) * 55'(PCT_SCALE);
      default:      m8_r <= m8_r;
    endcase
    if (cmd.out_load) begin
      out_healthy         <= healthy_r;
      out_broken          <= broken_r;
      out_isolation_ms    <= len_r;
      out_isolation_count <= tally_r;
    end
  end

  a_break_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(broken_r) |-> $past(cmd.op == OP_BREAK))
    else $error("broken set outside break step");

  a_clear_src: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(broken_r) |-> $past(cmd.op == OP_RESET))
    else $error("broken cleared outside reset step");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r >= ISO_W'(MIN_ISOLATION_MS)) && (len_r <= ISO_W'(MAX_ISOLATION_MS)))
    else $error("isolation duration out of range");

endmodule

// File: tb/ema_error_circuit_breaker_test.sv
// ----------------------------------------------------------------------------
// ema_error_circuit_breaker_test
// Drives call completions and resets into the EMA circuit breaker under
// random valid/stall gaps and register settings, predicts each result with a
// bit-accurate model of both windows and checks every result item in order.
// ----------------------------------------------------------------------------
module ema_error_circuit_breaker_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ema_cb_pkg::*;

  localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    logic        healthy;
    logic        broken;
    logic [14:0] iso_ms;
    logic [31:0] iso_count;
  } verdict_t;

  class breaker_scoreboard;
    logic [15:0] size_r[2];
    logic [6:0]  pct_r[2];
    logic [23:0] smooth_r[2];
    logic [31:0] min_cost;
    logic [15:0] eps;
    logic [15:0] samples[2];
    logic [15:0] errors[2];
    logic [31:0] avg_lat[2];
    logic [47:0] avg_cost[2];
    logic        broken;
    logic [47:0] last_reset;
    logic [14:0] iso_len;
    logic [31:0] tally;
    verdict_t    pending[$];
    int          fails;

    function new();
      size_r[0] = RST_LONG_SIZE; size_r[1] = RST_SHORT_SIZE;
      pct_r[0] = RST_LONG_PCT; pct_r[1] = RST_SHORT_PCT;
      smooth_r[0] = RST_LONG_SMOOTH; smooth_r[1] = RST_SHORT_SMOOTH;
      min_cost = RST_MIN_COST; eps = RST_EPS;
      foreach (samples[w]) begin
        samples[w] = 0; errors[w] = 0; avg_lat[w] = 0; avg_cost[w] = 0;
      end
      broken = 0; last_reset = 0; iso_len = 15'(MIN_ISOLATION_MS); tally = 0; fails = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] v);
      case (idx)
        CFG_LONG_SIZE:    size_r[0] = v[15:0];
        CFG_SHORT_SIZE:   size_r[1] = v[15:0];
        CFG_LONG_PCT:     pct_r[0] = v[6:0];
        CFG_SHORT_PCT:    pct_r[1] = v[6:0];
        CFG_LONG_SMOOTH:  smooth_r[0] = v[23:0];
        CFG_SHORT_SMOOTH: smooth_r[1] = v[23:0];
        CFG_MIN_COST:     min_cost = v;
        CFG_EPS:          eps = v[15:0];
        default:          ;
      endcase
    endfunction

    function bit cost_pass(int w, logic [31:0] lat_in, logic [31:0] ema);
      logic [33:0]  cost;
      logic [48:0]  sum;
      logic [127:0] budget;
      cost = lat_in;
      if (ema != 0 && 34'(ema) * LATENCY_MULTIPLE < cost) cost = 34'(ema) * LATENCY_MULTIPLE;
      if (cost != 0) begin
        sum = 49'(avg_cost[w]) + 49'(cost);
        if (sum > 49'(MASK48)) sum = 49'(MASK48);
        avg_cost[w] = sum[47:0];
        budget = 128'(ema) * size_r[w] * pct_r[w] * (128'd65536 + eps) / 128'd6553600;
        return 128'(sum) <= budget;
      end
      if (avg_cost[w] != 0) begin
        if (avg_cost[w] < 48'(min_cost)) avg_cost[w] = 0;
        else avg_cost[w] = 48'((72'(avg_cost[w]) * smooth_r[w]) >> 24);
      end
      return 1;
    endfunction

    function bit window_pass(int w, bit err, logic [31:0] lat);
      bit ok;
      logic [63:0] ema;
      logic [31:0] prior;
      if (!err) begin
        if (avg_lat[w] == 0) ema = lat;
        else ema = (64'(avg_lat[w]) * smooth_r[w] + 64'(lat) * (64'd1 << 24)
                    - 64'(lat) * smooth_r[w]) >> 24;
        avg_lat[w] = ema[31:0];
        ok = cost_pass(w, 0, avg_lat[w]);
      end else ok = cost_pass(w, lat, avg_lat[w]);
      if (samples[w] < size_r[w]) begin
        samples[w]++;
        if (err) begin
          prior = errors[w];
          if (errors[w] < 16'hFFFF) errors[w]++;
          return prior < 32'(size_r[w]) * pct_r[w] / PCT_SCALE;
        end
        return 1;
      end
      return ok;
    endfunction

    function void note_item(logic func, outcome_t oc, logic [31:0] lat, logic [47:0] now);
      verdict_t v;
      logic [15:0] dbl;
      if (func) begin
        for (int w = 0; w < 2; w++) begin
          if (samples[w] < size_r[w]) begin
            samples[w] = 0; errors[w] = 0; avg_lat[w] = 0;
          end
          avg_cost[w] = 0;
        end
        last_reset = now; broken = 0; v.healthy = 0;
      end else if (oc == OUT_REJECT) v.healthy = 1;
      else if (broken) v.healthy = 0;
      else if (window_pass(0, oc != OUT_SUCCESS, lat) &&
               window_pass(1, oc != OUT_SUCCESS, lat)) v.healthy = 1;
      else begin
        v.healthy = 0; broken = 1; tally++;
        if (now >= last_reset && now - last_reset >= MAX_ISOLATION_MS)
          iso_len = 15'(MIN_ISOLATION_MS);
        else begin
          dbl = 16'(iso_len) * 16'd2;
          iso_len = dbl < MAX_ISOLATION_MS ? dbl[14:0] : 15'(MAX_ISOLATION_MS);
        end
      end
      v.broken = broken; v.iso_ms = iso_len; v.iso_count = tally;
      pending.push_back(v);
    endfunction

    function void check_result(verdict_t got);
      verdict_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with none expected", $realtime);
        fails++;
        return;
      end
      e = pending.pop_front();
      if (got.healthy !== e.healthy) begin
        $display("%0t healthy exp %0d got %0d", $realtime, e.healthy, got.healthy); fails++;
      end
      if (got.broken !== e.broken) begin
        $display("%0t broken exp %0d got %0d", $realtime, e.broken, got.broken); fails++;
      end
      if (got.iso_ms !== e.iso_ms) begin
        $display("%0t isolation_ms exp %0d got %0d", $realtime, e.iso_ms, got.iso_ms); fails++;
      end
      if (got.iso_count !== e.iso_count) begin
        $display("%0t isolation_count exp %0d got %0d", $realtime, e.iso_count, got.iso_count);
        fails++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic        in_func = 0;
  logic [1:0]  in_outcome = 0;
  logic [31:0] in_latency_us = 0;
  logic [47:0] in_now_ms = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        out_healthy;
  logic        out_broken;
  logic [14:0] out_isolation_ms;
  logic [31:0] out_isolation_count;

  breaker_scoreboard sb = new();
  logic [47:0] clock_ms = 0;
  bit          hold_long = 0;
  bit          feeding_done = 0;

  ema_error_circuit_breaker dut (.*);

  always #5 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic func, outcome_t oc, logic [31:0] lat, logic [47:0] now);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1; in_func <= func; in_outcome <= oc;
    in_latency_us <= lat; in_now_ms <= now;
    do @(posedge clk); while (in_stall);
    sb.note_item(func, oc, lat, now);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic random_call(int err_pct, logic [31:0] lat_hi);
    int r;
    outcome_t oc;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      clock_ms = clock_ms + $urandom_range(0, 40000);
      send_item(1, OUT_SUCCESS, $urandom, clock_ms);
      return;
    end
    r = $urandom_range(0, 99);
    oc = r < err_pct ? OUT_ERROR : OUT_SUCCESS;
    if (r >= 96) oc = OUT_REJECT;
    else if (r >= 93) oc = OUT_OTHER;
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom & MASK48;
    else clock_ms = clock_ms + $urandom_range(0, 2000);
    send_item(0, oc, ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, lat_hi),
              $urandom_range(0, 29) == 0 ? 48'({$urandom, $urandom}) : clock_ms);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed
    send_item(0, OUT_SUCCESS, 0, 0);
    send_item(0, OUT_ERROR, 0, 5);
    send_item(0, OUT_SUCCESS, 32'hFFFF_FFFF, 10);
    send_item(0, OUT_ERROR, 32'hFFFF_FFFF, 20);
    send_item(0, OUT_OTHER, 1000, 30);
    send_item(0, OUT_REJECT, 32'hFFFF_FFFF, MASK48);
    send_item(1, OUT_OTHER, 32'hFFFF_FFFF, MASK48);
    send_item(0, OUT_SUCCESS, 500, 0);
    drain();
    write_reg(CFG_LONG_SIZE, 4);
    write_reg(CFG_SHORT_SIZE, 2);
    write_reg(CFG_LONG_PCT, 0);
    write_reg(CFG_SHORT_PCT, 99);
    write_reg(CFG_LONG_SMOOTH, 24'hFFFFFF);
    write_reg(CFG_SHORT_SMOOTH, 0);
    write_reg(CFG_MIN_COST, 32'hFFFF_FFFF);
    write_reg(CFG_EPS, 16'hFFFF);
    send_item(1, OUT_SUCCESS, 0, 100);
    for (int i = 0; i < 6; i++) send_item(0, OUT_SUCCESS, 200 + i, 200);
    send_item(0, OUT_ERROR, 5000, 300);
    send_item(0, OUT_ERROR, 5000, 310);
    send_item(0, OUT_SUCCESS, 100, 320);
    send_item(1, OUT_SUCCESS, 0, 400);
    send_item(0, OUT_ERROR, 1, 40000);
    send_item(1, OUT_SUCCESS, 0, 50);
    send_item(0, OUT_ERROR, 1, 10);
    drain();
    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_LONG_SIZE, ph == 0 ? 0 : (ph == 7 ? 16'hFFFF : $urandom_range(1, 40)));
      write_reg(CFG_SHORT_SIZE, ph == 1 ? 1 : $urandom_range(0, 30));
      write_reg(CFG_LONG_PCT, ph == 2 ? 99 : $urandom_range(0, 127));
      write_reg(CFG_SHORT_PCT, ph == 3 ? 0 : $urandom_range(0, 99));
      write_reg(CFG_LONG_SMOOTH, ph == 4 ? 0 : $urandom & 32'hFFFFFF);
      write_reg(CFG_SHORT_SMOOTH, ph == 5 ? 24'hFFFFFF : $urandom & 32'hFFFFFF);
      write_reg(CFG_MIN_COST, ph == 6 ? 0 : $urandom_range(0, 5000));
      write_reg(CFG_EPS, $urandom & 32'hFFFF);
      clock_ms = 0;
      send_item(1, OUT_SUCCESS, 0, 0);
      if (ph == 3) hold_long = 1;
      for (int i = 0; i < 100; i++)
        random_call(ph < 4 ? 10 : 40, ph[0] ? 32'd3000 : 32'hFFFF_FFFF);
      drain();
    end
    feeding_done = 1;
  end

  initial begin
    int g;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        hold_long = 0;
        out_stall <= 1;
        repeat (300) @(posedge clk);
        out_stall <= 0;
      end else if (out_stall) out_stall <= 0;
      else begin
        g = gap_len();
        if (g != 0) begin
          out_stall <= 1;
          repeat (g - 1) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    verdict_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.healthy = out_healthy; got.broken = out_broken;
      got.iso_ms = out_isolation_ms; got.iso_count = out_isolation_count;
      sb.check_result(got);
    end
  end

  initial begin
    wait (feeding_done);
    if (sb.fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule
